@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL of the radix digit converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RDC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define RDC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ rtl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and constants of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned BASE_W  = 4;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd10;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP,
    ST_OUT
  } rdc_state_e;

endpackage

@@ rtl/radix_digit_converter_core.sv @@
// Sequence: per digit, a bit-serial division over all VALUE_BITS dividend bits; then each
//   digit is popped from the stack and presented (plus output stall). An invalid base
//   skips the division and goes straight from idle to the output state.
// Throughput: one word at a time; the next input is taken after the last digit is taken.
//   The restoring divider (one quotient bit per cycle) sets the rate.
// Reset: rst_ni asynchronous, active low; clears the sequencer and the digit count.
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an unsigned integer to base 2..10 digits, streamed most significant
// first, using a bit-serial divider and a digit stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 31,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [BASE_W-1:0]     base_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic                  last_o,
  output logic                  error_o
);

  localparam int unsigned BCNT_W = $clog2(VALUE_BITS);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(VALUE_BITS - 1);
  localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(STACK_DEPTH - 1);

  rdc_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] val_q;
  logic [BASE_W-1:0]     base_q;
  logic [DIGIT_W-1:0]    rem_q;
  logic [BCNT_W-1:0]     bit_cnt_q;
  logic                  qnz_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIGIT_W-1:0]    rd_data_q;
  logic                  last_q;
  logic                  err_q;

  logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];

  logic               in_fire;
  logic               out_fire;
  logic               base_ok;
  logic [DIGIT_W:0]   trial;
  logic               ge;
  logic [DIGIT_W-1:0] rem_next;
  logic               div_done;
  logic               more_digits;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   cnt_dec;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign base_ok  = (base_i >= BASE_MIN) && (base_i <= BASE_MAX);

  // One restoring division step: bring down the next dividend bit
  assign trial    = {rem_q, val_q[VALUE_BITS-1]};
  assign ge       = trial >= {1'b0, base_q};
  assign rem_next = ge ? DIGIT_W'(trial - {1'b0, base_q}) : trial[DIGIT_W-1:0];
  assign div_done = (bit_cnt_q == BCNT_LAST);

  // Keep dividing while the quotient is nonzero and the stack has room
  assign more_digits = (qnz_q || ge) && (cnt_q < CNT_LIMIT);

  assign wr_addr = cnt_q[ADDR_W-1:0];
  assign cnt_dec = cnt_q - CNT_W'(1);
  assign rd_addr = cnt_dec[ADDR_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = base_ok ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done && !more_digits) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) begin
          state_d = last_q ? ST_IDLE : ST_POP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Digit count: cleared per word, up on each push, down on each pop
  always_comb begin
    cnt_d = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_POP: begin
        cnt_d = cnt_dec;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Handshake and output word
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    digit_o     = err_q ? '0 : rd_data_q;
    last_o      = last_q;
    error_o     = err_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Divider datapath and output flags
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          val_q     <= value_i;
          base_q    <= base_i;
          rem_q     <= '0;
          bit_cnt_q <= '0;
          qnz_q     <= 1'b0;
          err_q     <= !base_ok;
          last_q    <= 1'b1;
        end
      end
      ST_DIV: begin
        val_q <= {val_q[VALUE_BITS-2:0], ge};
        if (div_done) begin
          rem_q     <= '0;
          bit_cnt_q <= '0;
          qnz_q     <= 1'b0;
        end else begin
          rem_q     <= rem_next;
          bit_cnt_q <= bit_cnt_q + BCNT_W'(1);
          qnz_q     <= qnz_q || ge;
        end
      end
      ST_POP: begin
        last_q <= (cnt_dec == '0);
      end
      default: begin
        err_q <= err_q;
      end
    endcase
  end

  // Digit stack: push at the end of each division, pop into the output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      stack_mem[wr_addr] <= rem_next;
    end
    if (state_q == ST_POP) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  // Checks
  `RDC_ASSERT(a_err_single, clk_i, rst_ni, (out_valid_o && error_o) |-> (last_o && digit_o == '0), "error word must be a single zero digit")
  `RDC_ASSERT_NEVER(a_busy_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "input taken while a digit is pending")
  `RDC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(STACK_DEPTH), "digit count beyond stack depth")
  `RDC_ASSERT(a_last_idle, clk_i, rst_ni, (out_fire && last_o) |=> in_ready_o, "not idle after final digit")
  `RDC_ASSERT(a_last_empty, clk_i, rst_ni, (out_valid_o && last_o && !error_o) |-> (cnt_q == '0), "stack not empty on final digit")

endmodule
